>>> hdl/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg: shared types and codes of the priority sum tree
// Field widths of the stream payload, command and status codes, and the
// structs that pass a command and its result between the modules.
// ----------------------------------------------------------------------------
package pst_pkg;

  // Payload field widths as seen on the ports.
  localparam int CMD_W      = 2;
  localparam int LEAF_IDX_W = 10;
  localparam int PRIO_REQ_W = 24;
  localparam int TARGET_W   = 34;
  localparam int TOTAL_W    = 34;
  localparam int FILL_OUT_W = 11;
  localparam int STATUS_W   = 2;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNFILLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // One accepted command.
  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [LEAF_IDX_W-1:0] leaf_index;
    logic [PRIO_REQ_W-1:0] priority_req;
    logic [TARGET_W-1:0]   target_sum;
  } cmd_t;

  // One finished result.
  typedef struct packed {
    logic [LEAF_IDX_W-1:0] result_leaf;
    logic [PRIO_REQ_W-1:0] result_priority;
    logic [TOTAL_W-1:0]    total_sum;
    logic [FILL_OUT_W-1:0] fill_level;
    logic [STATUS_W-1:0]   status;
  } res_t;

endpackage

>>> hdl/pst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_ctrl: sum tree sequencer
// Owns the node RAM. Clears it after reset, climbs from a written leaf to the
// root one level per cycle, and descends from the root for a sample.
// ----------------------------------------------------------------------------
module pst_ctrl
  import pst_pkg::*;
#(
  parameter int LEAVES        = 1024,
  parameter int PRIORITY_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int LEAF_W = $clog2(LEAVES);
  localparam int NODE_W = LEAF_W + 1;
  localparam int FILL_W = LEAF_W + 1;
  localparam int SUM_W  = PRIORITY_BITS + LEAF_W;
  localparam int REST_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;
  localparam int IDX_W  = (FILL_W > LEAF_IDX_W) ? FILL_W : LEAF_IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CLIMB, S_DESCEND, S_LEAF_RD, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [NODE_W-1:0]     clr_r, clr_nxt;
  logic [NODE_W-1:0]     node_r, node_nxt;
  logic [SUM_W-1:0]      cur_r, cur_nxt;
  logic [REST_W-1:0]     rest_r, rest_nxt;
  logic [LEAF_W-1:0]     wp_r, wp_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [SUM_W-1:0]      total_r, total_nxt;
  logic [LEAF_IDX_W-1:0] res_leaf_r, res_leaf_nxt;
  logic [PRIO_REQ_W-1:0] res_prio_r, res_prio_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;

  logic                  mem_we;
  logic [NODE_W-1:0]     mem_waddr;
  logic [SUM_W-1:0]      mem_wdata;
  logic [NODE_W-1:0]     mem_raddr;
  logic [SUM_W-1:0]      mem_rdata;

  logic [PRIORITY_BITS-1:0] prio_v;
  logic [NODE_W-1:0]        parent;
  logic [SUM_W-1:0]         sum;
  logic [NODE_W-1:0]        child;
  logic [LEAF_W-1:0]        leaf_c;

  pst_ram #(
    .WIDTH (SUM_W),
    .DEPTH (2 * LEAVES)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  assign res.result_leaf     = res_leaf_r;
  assign res.result_priority = res_prio_r;
  assign res.total_sum       = TOTAL_W'(total_r);
  assign res.fill_level      = FILL_OUT_W'(fill_r);
  assign res.status          = res_status_r;

  // Next-state logic for the sequencer and the RAM port controls.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    node_nxt       = node_r;
    cur_nxt        = cur_r;
    rest_nxt       = rest_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    total_nxt      = total_r;
    res_leaf_nxt   = res_leaf_r;
    res_prio_nxt   = res_prio_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = node_r;
    mem_wdata      = cur_r;
    mem_raddr      = node_r;
    prio_v         = PRIORITY_BITS'(in_cmd.priority_req);
    parent         = node_r >> 1;
    sum            = cur_r + mem_rdata;
    child          = {node_r[NODE_W-2:0], 1'b0};
    leaf_c         = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        total_nxt = '0;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = ST_OK;
          res_leaf_nxt   = '0;
          res_prio_nxt   = '0;
          state_nxt      = S_DONE;
          case (in_cmd.command)
            CMD_ADD: begin
              // Write the leaf at the write pointer and start the climb.
              mem_we       = 1'b1;
              mem_waddr    = {1'b1, wp_r};
              mem_wdata    = SUM_W'(prio_v);
              mem_raddr    = {1'b1, wp_r} ^ NODE_W'(1);
              node_nxt     = {1'b1, wp_r};
              cur_nxt      = SUM_W'(prio_v);
              wp_nxt       = wp_r + 1'b1;
              if (fill_r != FILL_W'(LEAVES)) begin
                fill_nxt = fill_r + 1'b1;
              end
              res_leaf_nxt = LEAF_IDX_W'(wp_r);
              res_prio_nxt = PRIO_REQ_W'(prio_v);
              state_nxt    = S_CLIMB;
            end
            CMD_UPDATE: begin
              res_leaf_nxt = in_cmd.leaf_index;
              if (IDX_W'(in_cmd.leaf_index) < IDX_W'(fill_r)) begin
                mem_we       = 1'b1;
                mem_waddr    = {1'b1, LEAF_W'(in_cmd.leaf_index)};
                mem_wdata    = SUM_W'(prio_v);
                mem_raddr    = {1'b1, LEAF_W'(in_cmd.leaf_index)} ^ NODE_W'(1);
                node_nxt     = {1'b1, LEAF_W'(in_cmd.leaf_index)};
                cur_nxt      = SUM_W'(prio_v);
                res_prio_nxt = PRIO_REQ_W'(prio_v);
                state_nxt    = S_CLIMB;
              end else begin
                // Leaves past the fill count were never written and hold zero.
                res_status_nxt = ST_UNFILLED;
              end
            end
            CMD_SAMPLE: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                mem_raddr = NODE_W'(2);
                node_nxt  = NODE_W'(1);
                rest_nxt  = REST_W'(in_cmd.target_sum);
                state_nxt = S_DESCEND;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_CLIMB: begin
        // Parent gets this node plus its sibling; fetch the next sibling.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = sum;
        mem_raddr = parent ^ NODE_W'(1);
        node_nxt  = parent;
        cur_nxt   = sum;
        if (parent == NODE_W'(1)) begin
          total_nxt = sum;
          state_nxt = S_DONE;
        end
      end

      S_DESCEND: begin
        // Left sum is in mem_rdata; pick a child and fetch its left child.
        if (rest_r <= REST_W'(mem_rdata)) begin
          child = {node_r[NODE_W-2:0], 1'b0};
        end else begin
          child    = {node_r[NODE_W-2:0], 1'b1};
          rest_nxt = rest_r - REST_W'(mem_rdata);
        end
        node_nxt  = child;
        mem_raddr = {child[NODE_W-2:0], 1'b0};
        if (child[NODE_W-1]) begin
          // Landed on a leaf; clamp to the last filled leaf.
          leaf_c = child[LEAF_W-1:0];
          if (IDX_W'(leaf_c) >= IDX_W'(fill_r)) begin
            leaf_c = LEAF_W'(fill_r - 1'b1);
          end
          mem_raddr    = {1'b1, leaf_c};
          res_leaf_nxt = LEAF_IDX_W'(leaf_c);
          state_nxt    = S_LEAF_RD;
        end
      end

      S_LEAF_RD: begin
        res_prio_nxt = PRIO_REQ_W'(mem_rdata);
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      wp_r    <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      node_r       <= node_nxt;
      cur_r        <= cur_nxt;
      rest_r       <= rest_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      total_r      <= total_nxt;
      res_leaf_r   <= res_leaf_nxt;
      res_prio_r   <= res_prio_nxt;
      res_status_r <= res_status_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A finished climb always ends with a write of the root.
  a_climb_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLIMB && state_nxt == S_DONE) |-> (mem_we && mem_waddr == NODE_W'(1)))
    else $error("climb finished without a root write");

  // Until the ring is full the write pointer equals the fill count.
  a_wp_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FILL_W'(LEAVES)) |-> (FILL_W'(wp_r) == fill_r))
    else $error("write pointer and fill count disagree");

  // A sample lands on a filled leaf.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEAF_RD) |-> (IDX_W'(res_leaf_r) < IDX_W'(fill_r)))
    else $error("sample landed beyond the last filled leaf");

  // A result waiting for the output stage holds still.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_ready) |=>
      (state_r == S_DONE && $stable(res_leaf_r) && $stable(res_prio_r)))
    else $error("pending result changed");
`endif

endmodule

>>> hdl/priority_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sum_tree: prioritized replay sum tree
// Binary sum tree over a ring of leaf priorities with add, update and sample
// commands, streaming input and output with a registered output stage.
// ----------------------------------------------------------------------------
// The tree lives in one node RAM of 2*LEAVES entries (LEAVES a power of two)
// with one read and one write port, and add, update and sample walk it one
// level per cycle. After reset the block clears the RAM with in_tready low.
// Then add and update do one read-modify-write of a parent node per level
// on the way to the root. Sample does one left-child read per level on the
// way down and one read of the leaf it lands on. An update of an unfilled
// leaf, a sample on an empty tree and an unused command touch no node. The
// result sits in an output register, so the next command is taken while the
// previous result still waits for out_tready.
module priority_sum_tree
  import pst_pkg::*;
#(
  parameter int LEAVES        = 1024,
  parameter int PRIORITY_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [9:0] leaf_index, [33:10] priority_req, [67:34] target_sum, rest zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [9:0] result_leaf, [33:10] result_priority, [67:34] total_sum,
  // [78:68] fill_level, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0]    out_tuser
);

  cmd_t in_cmd;
  res_t res;
  logic res_valid;
  logic res_ready;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // Unpack the input transfer.
  assign in_cmd.command      = in_tuser;
  assign in_cmd.leaf_index   = in_tdata[9:0];
  assign in_cmd.priority_req = in_tdata[33:10];
  assign in_cmd.target_sum   = in_tdata[67:34];

  pst_ctrl #(
    .LEAVES        (LEAVES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads when empty or when its result is taken.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (res_valid && res_ready) begin
        out_res_r <= res;
      end
    end
  end

  // Pack the output transfer.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.fill_level, out_res_r.total_sum,
                       out_res_r.result_priority, out_res_r.result_leaf};
  assign out_tuser  = out_res_r.status;

endmodule
